### hdl/asmon_pkg.sv
// asmon_pkg: shared constants, register indexes and field widths for the
// ambient sensor monitor. Depends on nothing; used by ambient_sensor_monitor_unit.
`timescale 1ns / 1ps

package asmon_pkg;

   // filter and seeding
   localparam int unsigned FILTER_BITS  = 3;
   localparam logic [3:0]  SEED_SAMPLES = 4'd8;
   localparam int unsigned SEED_LOG2    = $clog2(SEED_SAMPLES);

   // field widths
   localparam int unsigned LIGHT_W = 12;
   localparam int unsigned FILT_W  = 15;
   localparam int unsigned RAW_W   = 20;
   localparam int unsigned TEMP_W  = 9;
   localparam int unsigned HUM_W   = 7;
   localparam int unsigned REQ_W   = 64;
   localparam int unsigned RSP_W   = 56;
   localparam int unsigned ADDR_W  = 4;

   // light outputs
   localparam logic [11:0] DUTY_FLOOR = 12'd100;

   // frame decode
   localparam int unsigned BUSY_BIT = 7;

   // fixed point conversion, 20 fractional bits
   localparam logic [27:0] TEMP_SCALE  = 28'd200;
   localparam logic [27:0] TEMP_OFFSET = 28'd52428800;   // 50 << 20
   localparam logic [7:0]  TEMP_BIAS   = 8'd50;
   localparam logic [26:0] HUM_SCALE   = 27'd100;

   // reset values
   localparam logic [19:0] TEMP_RAW_RESET = 20'd262144;  // zero degrees
   localparam logic [5:0]  TEMP_LIMIT_RESET = 6'd28;
   localparam logic [6:0]  HUM_LOW_RESET    = 7'd40;
   localparam logic [6:0]  HUM_HIGH_RESET   = 7'd80;
   localparam logic [11:0] DARK_LIMIT_RESET = 12'd800;

   // item kinds on req_tuser
   localparam logic OP_LIGHT = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   // register index, byte address bits [3:2]
   typedef enum logic [1:0] {
      REG_TEMP_LIMIT = 2'd0,
      REG_HUM_LOW    = 2'd1,
      REG_HUM_HIGH   = 2'd2,
      REG_DARK_LIMIT = 2'd3
   } reg_index_type;

endpackage

### hdl/ambient_sensor_monitor_unit.sv
// ambient_sensor_monitor_unit: light filter and humidity/temperature monitor.
// Depends on asmon_pkg for constants and register indexes.
`timescale 1ns / 1ps

// Usage
// req channel: one item per handshake; req_tuser selects a light sample (0)
//   or a six-byte sensor frame (1). Light state and raw climate values are
//   updated at the edge the item is accepted.
// rsp channel: one result per item once the first eight light samples have
//   seeded the filter; items during seeding (including the eighth sample)
//   give no result. Busy frames leave the state alone but still give a result.
// Order: an accepted item updates the state registers at the edge it is taken;
//   its result then enters the output register once that register is empty or read.
// Throughput: one item per cycle while rsp_tready is high; the conversion is
//   one 20x8 multiply and a compare per climate value between the state
//   registers and the output register.
// Stall: one held item in the middle stage plus the output register; req_tready
//   drops only while both are full and rsp_tready is low.
// Reset: synchronous, clears the seeding state, the filter, the raw climate
//   values (temperature reads zero degrees) and loads the register defaults.
// csr: APB-style, registers at byte addresses 0, 4, 8, 12; write only while idle.
module ambient_sensor_monitor_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // light_sample[11:0], frame_status[19:12], frame_byte1[27:20],
   // frame_byte2[35:28], frame_byte3[43:36], frame_byte4[51:44],
   // frame_byte5[59:52], zero[63:60]
   input  logic [63:0] req_tdata,
   // op[0]
   input  logic        req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // light_level[11:0], backlight_duty[23:12], led_level[35:24],
   // temperature_c[44:36], humidity_pct[51:45], hot[52], dry[53],
   // dark[54], warning[55]
   output logic [55:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [5:0]  temp_limit_ff;
   logic [6:0]  hum_low_ff;
   logic [6:0]  hum_high_ff;
   logic [11:0] dark_limit_ff;
   logic        csr_write;
   asmon_pkg::reg_index_type csr_index;

   // item state
   logic [3:0]  seed_count_ff, seed_count_in;
   logic [14:0] seed_sum_ff, seed_sum_in;
   logic [14:0] filter_ff, filter_in;
   logic [19:0] temp_raw_ff, temp_raw_in;
   logic [19:0] hum_raw_ff, hum_raw_in;
   logic        mid_valid_ff, mid_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;

   // input decode
   logic        accept;
   logic        advance;
   logic        seeding;
   logic [11:0] sample;
   logic [7:0]  frame_status;
   logic [7:0]  byte1, byte2, byte3, byte4, byte5;
   logic [3:0]  count_next;
   logic [14:0] sum_next;

   // conversion
   logic [11:0] light;
   logic [11:0] led;
   logic [11:0] duty;
   logic [27:0] t_scaled;
   logic [27:0] t_above;
   logic [27:0] t_below;
   logic signed [8:0] t_deg;
   logic [26:0] h_scaled;
   logic [6:0]  h_pct;
   logic        hot, dry, dark, warn;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = asmon_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_limit_ff <= asmon_pkg::TEMP_LIMIT_RESET;
         hum_low_ff    <= asmon_pkg::HUM_LOW_RESET;
         hum_high_ff   <= asmon_pkg::HUM_HIGH_RESET;
         dark_limit_ff <= asmon_pkg::DARK_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            asmon_pkg::REG_TEMP_LIMIT: temp_limit_ff <= csr_pwdata[5:0];
            asmon_pkg::REG_HUM_LOW:    hum_low_ff    <= csr_pwdata[6:0];
            asmon_pkg::REG_HUM_HIGH:   hum_high_ff   <= csr_pwdata[6:0];
            asmon_pkg::REG_DARK_LIMIT: dark_limit_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (csr_index)
         asmon_pkg::REG_TEMP_LIMIT: csr_prdata = {26'd0, temp_limit_ff};
         asmon_pkg::REG_HUM_LOW:    csr_prdata = {25'd0, hum_low_ff};
         asmon_pkg::REG_HUM_HIGH:   csr_prdata = {25'd0, hum_high_ff};
         asmon_pkg::REG_DARK_LIMIT: csr_prdata = {20'd0, dark_limit_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // ---------------- handshake ----------------
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !mid_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- state update on accept ----------------
   assign sample       = req_tdata[11:0];
   assign frame_status = req_tdata[19:12];
   assign byte1        = req_tdata[27:20];
   assign byte2        = req_tdata[35:28];
   assign byte3        = req_tdata[43:36];
   assign byte4        = req_tdata[51:44];
   assign byte5        = req_tdata[59:52];

   assign seeding    = seed_count_ff < asmon_pkg::SEED_SAMPLES;
   assign count_next = seed_count_ff + 4'd1;
   assign sum_next   = seed_sum_ff + {3'd0, sample};

   always_comb begin
      seed_count_in = seed_count_ff;
      seed_sum_in   = seed_sum_ff;
      filter_in     = filter_ff;
      temp_raw_in   = temp_raw_ff;
      hum_raw_in    = hum_raw_ff;
      if (accept) begin
         if (req_tuser == asmon_pkg::OP_LIGHT) begin
            if (seeding) begin
               // seed: sum samples, load the average once the count is full
               seed_sum_in   = sum_next;
               seed_count_in = count_next;
               if (count_next >= asmon_pkg::SEED_SAMPLES) begin
                  filter_in = (sum_next >> asmon_pkg::SEED_LOG2) << asmon_pkg::FILTER_BITS;
               end
            end else begin
               // exponential average, wraps in 15 bits
               filter_in = filter_ff - (filter_ff >> asmon_pkg::FILTER_BITS)
                           + {3'd0, sample};
            end
         end else if (!frame_status[asmon_pkg::BUSY_BIT]) begin
            // idle sensor frame: unpack raw humidity and temperature
            hum_raw_in  = {byte1, byte2, byte3[7:4]};
            temp_raw_in = {byte3[3:0], byte4, byte5};
         end
      end
   end

   // middle stage holds a pending result slot
   always_comb begin
      if (accept) begin
         mid_valid_in = !seeding;
      end else if (advance) begin
         mid_valid_in = 1'b0;
      end else begin
         mid_valid_in = mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_count_ff <= 4'd0;
         seed_sum_ff   <= 15'd0;
         filter_ff     <= 15'd0;
         temp_raw_ff   <= asmon_pkg::TEMP_RAW_RESET;
         hum_raw_ff    <= 20'd0;
         mid_valid_ff  <= 1'b0;
      end else begin
         seed_count_ff <= seed_count_in;
         seed_sum_ff   <= seed_sum_in;
         filter_ff     <= filter_in;
         temp_raw_ff   <= temp_raw_in;
         hum_raw_ff    <= hum_raw_in;
         mid_valid_ff  <= mid_valid_in;
      end
   end

   // ---------------- conversion from state ----------------
   // light outputs
   assign light = 12'(filter_ff >> asmon_pkg::FILTER_BITS);
   assign led   = ~light;
   assign duty  = (led < asmon_pkg::DUTY_FLOOR) ? asmon_pkg::DUTY_FLOOR : led;
   assign dark  = light > dark_limit_ff;

   // temperature: raw * 200 / 2^20 - 50, truncated toward zero
   assign t_scaled = {8'd0, temp_raw_ff} * asmon_pkg::TEMP_SCALE;
   assign t_above  = t_scaled - asmon_pkg::TEMP_OFFSET;
   assign t_below  = asmon_pkg::TEMP_OFFSET - t_scaled;
   always_comb begin
      if (t_scaled >= asmon_pkg::TEMP_OFFSET) begin
         t_deg = signed'({1'b0, t_above[27:20]});
      end else begin
         t_deg = signed'(9'd0 - {1'b0, t_below[27:20]});
      end
   end
   assign hot = t_scaled[27:20] >= ({2'd0, temp_limit_ff} + asmon_pkg::TEMP_BIAS);

   // humidity: raw * 100 / 2^20, floor
   assign h_scaled = {7'd0, hum_raw_ff} * asmon_pkg::HUM_SCALE;
   assign h_pct    = h_scaled[26:20];
   assign dry      = h_pct < hum_low_ff;
   assign warn     = hot || (h_pct >= hum_high_ff);

   assign rsp_data_in = {warn, dark, dry, hot, h_pct, t_deg, led, duty, light};

   // ---------------- output register ----------------
   assign rsp_valid_in = advance ? mid_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- assertions ----------------
   // a full pipe with a stalled receiver takes no new item
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("item accepted while pipe full");

   // nothing is pending for output until seeding is over
   a_no_result_seeding: assert property (@(posedge clock) disable iff (reset)
      (seed_count_ff < asmon_pkg::SEED_SAMPLES) |-> (!mid_valid_ff && !rsp_valid_ff))
      else $error("result pending during seeding");

   // seed counter stops at the seed length
   a_seed_count_bound: assert property (@(posedge clock) disable iff (reset)
      seed_count_ff <= asmon_pkg::SEED_SAMPLES)
      else $error("seed count past limit");

   // a pending result with a free output stage and no new item moves on at the next edge
   a_mid_drains: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && advance && !accept) |=> !mid_valid_ff)
      else $error("middle stage did not drain");

endmodule
